// File: src/dgd_pkg.sv
// Package for the double Gaussian density block: types, constants, exp table.
`timescale 1ns / 1ps
`default_nettype none
package dgd_pkg;

  // Field widths
  localparam int MASS_W   = 20;
  localparam int SEL_W    = 2;
  localparam int DENS_W   = 32;
  localparam int FRAC_W   = 17;
  localparam int WID_W    = 16;
  localparam int PEAK_W   = 20;
  localparam int CFG_W    = 20;
  localparam int CFG_IDX_W = 2;

  // Arithmetic
  localparam int EXP_N       = 256;              // exp table intervals
  localparam int RES_FRAC    = 24;               // result fraction bits
  localparam int DENS_SHIFT  = 32 - RES_FRAC;
  localparam int TAB_IDX_W   = $clog2(EXP_N + 1);
  localparam int E_W         = 31;               // Q30, up to 1.0
  localparam int A_W         = 38;               // amplitude quotient
  localparam int DD_W        = 2 * MASS_W;       // squared distance
  localparam int X_W         = 20;               // x in Q16 below 16.0
  localparam int XR_W        = 53;               // x divider remainder
  localparam int DEN_W       = 33;               // 2*s*s
  localparam int TERM_W      = 38;
  localparam int SUM_W       = TERM_W + 1;
  localparam int DIV_STAGES  = A_W;              // one quotient bit a stage
  localparam int X_BITS      = X_W;
  localparam logic [A_W-1:0] A_NUM = 38'd219320838016; // 2^32/sqrt(2pi)*128

  localparam logic [FRAC_W-1:0] ONE_Q16      = 17'd65536;
  localparam logic [FRAC_W-1:0] SINGLE_LIMIT = 17'd65530;

  typedef enum logic [SEL_W-1:0] {
    SEL_MIX    = 2'd0,
    SEL_FIRST  = 2'd1,
    SEL_SECOND = 2'd2,
    SEL_UNUSED = 2'd3
  } comp_sel_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FIRST_FRACTION = 2'd0,
    REG_FIRST_WIDTH    = 2'd1,
    REG_SECOND_WIDTH   = 2'd2,
    REG_PEAK_MASS      = 2'd3
  } cfg_reg_e;

  localparam logic [FRAC_W-1:0] RST_FIRST_FRACTION = 17'd65536;
  localparam logic [WID_W-1:0]  RST_FIRST_WIDTH    = 16'd2560;
  localparam logic [WID_W-1:0]  RST_SECOND_WIDTH   = 16'd5120;
  localparam logic [PEAK_W-1:0] RST_PEAK_MASS      = 20'd686848;

  typedef struct packed {
    logic [MASS_W-1:0] mass;
    logic [SEL_W-1:0]  component_select;
  } dgd_in_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              saturated;
  } dgd_out_t;

  typedef logic [E_W-1:0] exp_tab_t [EXP_N+1];

  // exp(-x) samples over [0,16], Q30, built at elaboration
  function automatic exp_tab_t build_exp_tab();
    logic [127:0] z;
    logic [127:0] t;
    logic [127:0] plus;
    logic [127:0] minus;
    logic [127:0] e1;
    logic [127:0] acc;
    exp_tab_t     tab;
    z     = (128'd16 << 30) / 128'(EXP_N);
    t     = 128'd1 << 30;
    plus  = t;
    minus = '0;
    for (int k = 1; k <= 30; k++) begin
      if (t != 0) begin
        t = ((t * z) >> 30) / 128'(k);
        if ((k % 2) == 1) minus = minus + t;
        else plus = plus + t;
      end
    end
    e1     = plus - minus;
    acc    = 128'd1 << 30;
    tab[0] = E_W'(acc);
    for (int i = 1; i <= EXP_N; i++) begin
      acc    = (acc * e1 + (128'd1 << 29)) >> 30;
      tab[i] = E_W'(acc);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

endpackage
`default_nettype wire

// File: src/double_gaussian_density_top.sv
// Top level: fully pipelined double Gaussian mixture density, one transaction a cycle.
//
//  channel  | handshake            | payload
//  ---------+----------------------+---------------------------------------
//  item     | start_i / busy_o     | item_i   (mass, component_select)
//  result   | valid_o (1 cycle)    | result_o (density, saturated)
//  config   | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// A transaction's result and its valid_o strobe leave the output stage together.
// A new one can be taken every cycle, so busy_o is always low. The latency is
// set by the two restoring dividers (38 stages) that give the amplitude 1/sigma
// and the exponent argument d^2/(2 sigma^2) per term. The amplitude divider gives
// one quotient bit per stage, the exponent divider one in stages 1..X_BITS only.
// Reset (async, active low) clears the valid pipeline and loads register
// defaults. The receiver cannot stall: results flow out on their strobe.
`timescale 1ns / 1ps
`default_nettype none
module double_gaussian_density_top import dgd_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire dgd_in_t              item_i,
  output logic                      valid_o,
  output dgd_out_t                  result_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [CFG_W-1:0]     cfg_data_i
);

  // Stage map: 0 input, 1 square, 2..39 dividers, then table, interpolate
  // (two), amplitude multiply (two), weighting, output.
  localparam int ST_SQ  = 1;
  localparam int ST_D0  = ST_SQ + 1;
  localparam int ST_TAB = ST_D0 + DIV_STAGES;
  localparam int ST_E1  = ST_TAB + 1;
  localparam int ST_E2  = ST_E1 + 1;
  localparam int ST_M1  = ST_E2 + 1;
  localparam int ST_M2  = ST_M1 + 1;
  localparam int ST_W   = ST_M2 + 1;
  localparam int ST_OUT = ST_W + 1;
  localparam int LAT    = ST_OUT + 1;

  // ---------------- configuration ----------------
  logic [FRAC_W-1:0] first_fraction_q;
  logic [WID_W-1:0]  first_width_q;
  logic [WID_W-1:0]  second_width_q;
  logic [PEAK_W-1:0] peak_mass_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_fraction_q <= RST_FIRST_FRACTION;
      first_width_q    <= RST_FIRST_WIDTH;
      second_width_q   <= RST_SECOND_WIDTH;
      peak_mass_q      <= RST_PEAK_MASS;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FIRST_FRACTION: first_fraction_q <= cfg_data_i[FRAC_W-1:0];
        REG_FIRST_WIDTH:    first_width_q    <= cfg_data_i[WID_W-1:0];
        REG_SECOND_WIDTH:   second_width_q   <= cfg_data_i[WID_W-1:0];
        REG_PEAK_MASS:      peak_mass_q      <= cfg_data_i[PEAK_W-1:0];
        default: ;
      endcase
    end
  end

  // Derived settings, registered from the configuration registers; an item needs them
  // only from the divider stages on.
  logic [WID_W-1:0]  sig_q [2];
  logic [DEN_W-1:0]  den_q [2];
  logic [FRAC_W-1:0] w_q;
  logic              single_q;
  logic [WID_W-1:0]  sig_d [2];
  logic [FRAC_W-1:0] w_d;

  always_comb begin
    sig_d[0] = (first_width_q == '0) ? WID_W'(1) : first_width_q;
    sig_d[1] = (second_width_q == '0) ? WID_W'(1) : second_width_q;
    w_d      = (first_fraction_q > ONE_Q16) ? ONE_Q16 : first_fraction_q;
  end

  always_ff @(posedge clk_i) begin
    for (int t = 0; t < 2; t++) begin
      sig_q[t] <= sig_d[t];
      den_q[t] <= {(DEN_W-1)'(sig_d[t] * sig_d[t]), 1'b0};
    end
    w_q      <= w_d;
    single_q <= (w_d >= SINGLE_LIMIT);
  end

  // ---------------- control pipeline ----------------
  logic                 vld_q [LAT];
  logic [SEL_W-1:0]     sel_q [LAT];
  logic                 accept;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < LAT; i++) vld_q[i] <= 1'b0;
    end else begin
      vld_q[0] <= accept;
      for (int i = 1; i < LAT; i++) vld_q[i] <= vld_q[i-1];
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q[0] <= item_i.component_select;
    for (int i = 1; i < LAT; i++) sel_q[i] <= sel_q[i-1];
  end

  // ---------------- distance and square ----------------
  logic [MASS_W-1:0] d_q;
  logic [DD_W-1:0]   dd_q;

  always_ff @(posedge clk_i) begin
    d_q  <= (item_i.mass >= peak_mass_q) ? (item_i.mass - peak_mass_q)
                                         : (peak_mass_q - item_i.mass);
    dd_q <= DD_W'(d_q * d_q);
  end

  // ---------------- per-term arithmetic ----------------
  for (genvar t = 0; t < 2; t++) begin : g_term
    logic [A_W-1:0]  ar_q [DIV_STAGES];   // amplitude remainder
    logic [A_W-1:0]  aq_q [DIV_STAGES];   // amplitude quotient
    logic [XR_W-1:0] xr_q [DIV_STAGES];   // exponent remainder
    logic [X_W-1:0]  xq_q [DIV_STAGES];   // exponent quotient
    logic            ovf_q [DIV_STAGES];  // x at or beyond 16.0

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
      localparam int AB = A_W - 1 - j;    // amplitude bit of this stage
      // exponent bit of this stage, only meaningful for stages 1..X_BITS
      localparam int XB = (j >= 1 && j <= X_BITS) ? X_BITS - j : 0;
      logic [A_W-1:0]  ar_in, ar_d, aq_in, aq_d;
      logic [XR_W-1:0] xr_in, xr_d;
      logic [X_W-1:0]  xq_in, xq_d;
      logic            ovf_in, ovf_d;
      logic [A_W+WID_W-1:0] a_trial;
      logic [XR_W-1:0]      x_trial;

      if (j == 0) begin : g_load
        logic [DD_W+16-1:0] x_num;
        assign x_num  = {dd_q, 16'b0};
        assign ar_in  = A_NUM;
        assign aq_in  = '0;
        assign xq_in  = '0;
        assign ovf_in = ({3'b0, x_num} >= (59'(den_q[t]) << X_BITS));
        assign xr_in  = XR_W'(x_num);
      end else begin : g_chain
        assign ar_in  = ar_q[j-1];
        assign aq_in  = aq_q[j-1];
        assign xq_in  = xq_q[j-1];
        assign ovf_in = ovf_q[j-1];
        assign xr_in  = xr_q[j-1];
      end

      always_comb begin
        a_trial = (A_W+WID_W)'(sig_q[t]) << AB;
        ar_d = ar_in;
        aq_d = aq_in;
        if ({{WID_W{1'b0}}, ar_in} >= a_trial) begin
          ar_d     = ar_in - A_W'(a_trial);
          aq_d[AB] = 1'b1;
        end
        xr_d    = xr_in;
        xq_d    = xq_in;
        ovf_d   = ovf_in;
        x_trial = '0;
        if (j >= 1 && j <= X_BITS) begin
          x_trial = XR_W'(den_q[t]) << XB;
          if (xr_in >= x_trial) begin
            xr_d     = xr_in - x_trial;
            xq_d[XB] = 1'b1;
          end
        end
      end

      always_ff @(posedge clk_i) begin
        ar_q[j]  <= ar_d;
        aq_q[j]  <= aq_d;
        xr_q[j]  <= xr_d;
        xq_q[j]  <= xq_d;
        ovf_q[j] <= ovf_d;
      end
    end

    // table lookup
    logic [31:0]          pos;
    logic [TAB_IDX_W-1:0] idx;
    logic [E_W-1:0]       ta_q, tb_q;
    logic [15:0]          fr_q;
    logic                 ovf_t_q, ovf_e1_q;
    logic [A_W-1:0]       a_t_q, a_e1_q, a_e2_q;
    logic [E_W+16-1:0]    dprod_q;
    logic [E_W-1:0]       ta_e1_q;
    logic [E_W-1:0]       e_q;
    logic [A_W+16-1:0]    phi_q;
    logic [A_W+15-1:0]    plo_q;
    logic [TERM_W-1:0]    term_q;

    always_comb begin
      pos = (32'(xq_q[DIV_STAGES-1]) * 32'(EXP_N)) >> 4;
      idx = pos[16 +: TAB_IDX_W];
    end

    always_ff @(posedge clk_i) begin
      // table read
      ta_q    <= EXP_TAB[idx];
      tb_q    <= EXP_TAB[idx + TAB_IDX_W'(1)];
      fr_q    <= pos[15:0];
      ovf_t_q <= ovf_q[DIV_STAGES-1];
      a_t_q   <= aq_q[DIV_STAGES-1];
      // interpolation product
      dprod_q  <= (E_W+16)'((ta_q - tb_q) * fr_q);
      ta_e1_q  <= ta_q;
      ovf_e1_q <= ovf_t_q;
      a_e1_q   <= a_t_q;
      // interpolated exponential, zero in the far tail
      e_q      <= ovf_e1_q ? '0 : (ta_e1_q - dprod_q[E_W+16-1:16]);
      a_e2_q   <= a_e1_q;
      // amplitude times exponential, split in high and low halves
      phi_q  <= (A_W+16)'(a_e2_q * e_q[E_W-1:15]);
      plo_q  <= (A_W+15)'(a_e2_q * e_q[14:0]);
      term_q <= TERM_W'(phi_q[A_W+16-1:15]) + TERM_W'(plo_q[A_W+15-1:30]);
    end
  end

  // ---------------- weighting ----------------
  logic [TERM_W-1:0] wt1_q, wt2_q;
  logic              use1, use2;
  logic [TERM_W+FRAC_W-1:0] p1, p2;

  always_comb begin
    use1 = (sel_q[ST_M2] != SEL_SECOND);
    use2 = !single_q && (sel_q[ST_M2] != SEL_FIRST);
    p1   = (TERM_W+FRAC_W)'(g_term[0].term_q * w_q);
    p2   = (TERM_W+FRAC_W)'(g_term[1].term_q * (ONE_Q16 - w_q));
  end

  always_ff @(posedge clk_i) begin
    if (!use1) wt1_q <= '0;
    else if (single_q) wt1_q <= g_term[0].term_q;
    else wt1_q <= p1[16 +: TERM_W];
    wt2_q <= use2 ? p2[16 +: TERM_W] : '0;
  end

  // ---------------- output ----------------
  logic [SUM_W-1:0] sum, dens_full;

  always_comb begin
    sum       = SUM_W'(wt1_q) + SUM_W'(wt2_q);
    dens_full = sum >> DENS_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (|dens_full[SUM_W-1:DENS_W]) begin
      result_o.density   <= '1;
      result_o.saturated <= 1'b1;
    end else begin
      result_o.density   <= dens_full[DENS_W-1:0];
      result_o.saturated <= 1'b0;
    end
  end

  assign valid_o = vld_q[ST_OUT];

  // ---------------- assertions ----------------
  // every accepted transaction comes out after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##LAT valid_o)
    else $error("result missing after pipeline latency");

  // the weighting stage valid always reaches the strobe in the next cycle
  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[ST_W] |=> valid_o)
    else $error("valid lost in last stage");

  // single Gaussian mode: second-term selector yields zero
  a_single_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[ST_M2] && single_q && sel_q[ST_M2] == SEL_SECOND)
      |=> ##1 (result_o.density == '0 && !result_o.saturated))
    else $error("second term not zero in single mode");

endmodule
`default_nettype wire
